// ----- sv/spi_adc_register_interface_unit_defines.svh -----
// assertion macros for the spi adc register interface unit
// no dependencies; included by the top level
`ifndef SPI_ADC_REGISTER_INTERFACE_UNIT_DEFINES_SVH
`define SPI_ADC_REGISTER_INTERFACE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPIADC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPIADC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/spiadc_pkg.sv -----
// types, constants and address decode helpers of the spi adc register interface
// no dependencies; imported by spiadc_ctrl and the top level
package spiadc_pkg;

    localparam int NUM_CHANNELS     = 16;
    localparam int NUM_SETUPS       = 8;
    localparam int RESET_ONES_BYTES = 8;

    localparam int ADDR_W     = 6;
    localparam int STORE_W    = 24;
    localparam int STORE_DEPTH = 64;

    localparam logic [1:0] CMD_SERIAL = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_STATUS     = 6'h00;
    localparam logic [ADDR_W-1:0] ADDR_CTRL       = 6'h01;
    localparam logic [ADDR_W-1:0] ADDR_DATA       = 6'h02;
    localparam logic [ADDR_W-1:0] ADDR_IO1        = 6'h03;
    localparam logic [ADDR_W-1:0] ADDR_IO2        = 6'h04;
    localparam logic [ADDR_W-1:0] ADDR_ID         = 6'h05;
    localparam logic [ADDR_W-1:0] ADDR_ERROR      = 6'h06;
    localparam logic [ADDR_W-1:0] ADDR_ERROR_EN   = 6'h07;
    localparam logic [ADDR_W-1:0] ADDR_CLKCNT     = 6'h08;
    localparam logic [ADDR_W-1:0] ADDR_CH_BASE    = 6'h09;
    localparam logic [ADDR_W-1:0] ADDR_SETUP_BASE = 6'h19;
    localparam logic [ADDR_W-1:0] ADDR_WIDE_BASE  = 6'h21;
    localparam logic [ADDR_W-1:0] ADDR_UNIMPL     = 6'h39;

    localparam int  COMM_INVALID_BIT = 7;
    localparam int  COMM_READ_BIT    = 6;
    localparam int  CTRL_APPEND_BIT  = 10;
    localparam logic [7:0] STATUS_NRDY = 8'h80;
    localparam logic [7:0] STATUS_ERR  = 8'h40;
    localparam logic [7:0] ALL_ONES    = 8'hff;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  mosi_byte;
        logic [23:0] sample_value;
        logic [3:0]  sample_channel;
        logic [23:0] error_bits;
    } t_item;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       access_done;
    } t_result;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_READ  = 3'b010,
        PH_WRITE = 3'b100
    } t_phase;

    function automatic logic [2:0] reg_size(input logic [ADDR_W-1:0] a);
        logic [2:0] n;
        if (a >= ADDR_WIDE_BASE || a inside {ADDR_DATA, ADDR_IO1, ADDR_ERROR, ADDR_ERROR_EN}) begin
            n = 3'd3;
        end else if (a >= ADDR_CH_BASE || a inside {ADDR_CTRL, ADDR_IO2}) begin
            n = 3'd2;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    function automatic logic [STORE_W-1:0] size_mask(input logic [2:0] n);
        logic [STORE_W-1:0] m;
        case (n)
            3'd3:    m = 24'hffffff;
            3'd2:    m = 24'h00ffff;
            default: m = 24'h0000ff;
        endcase
        return m;
    endfunction

    function automatic logic implemented(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] ch_off;
        logic [ADDR_W-1:0] su_off;
        logic              ok;
        ch_off = a - ADDR_CH_BASE;
        su_off = a - ADDR_SETUP_BASE;
        if (a >= ADDR_CH_BASE && a < ADDR_SETUP_BASE) begin
            ok = 7'(ch_off) < 7'(NUM_CHANNELS);
        end else if (a >= ADDR_SETUP_BASE && a < ADDR_UNIMPL) begin
            ok = {1'b0, su_off[2:0]} < 4'(NUM_SETUPS);
        end else begin
            ok = a < ADDR_UNIMPL;
        end
        return ok;
    endfunction

    function automatic logic read_only(input logic [ADDR_W-1:0] a);
        return a inside {ADDR_STATUS, ADDR_DATA, ADDR_ID, ADDR_ERROR, ADDR_CLKCNT};
    endfunction

endpackage

// ----- sv/spiadc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module spiadc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/spiadc_ctrl.sv -----
// serial access sequencer: register store in ram, status/data/error/clock registers
// depends on spiadc_pkg and spiadc_ram
module spiadc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  spiadc_pkg::t_item  i_item,
    input  logic [7:0]         i_device_id,
    output logic               o_busy,
    output logic               o_strobe,
    output spiadc_pkg::t_result o_result
);
    import spiadc_pkg::*;

    logic                   r_busy, n_busy;
    t_item                  r_item;
    t_phase                 r_phase, n_phase;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [2:0]             r_bytes_left, n_bytes_left;
    logic [31:0]            r_shift, n_shift;
    logic [3:0]             r_ones, n_ones;
    logic [23:0]            r_data, n_data;
    logic [7:0]             r_status, n_status;
    logic [23:0]            r_error, n_error;
    logic [7:0]             r_clkcnt, n_clkcnt;
    logic [STORE_DEPTH-1:0] r_valid, n_valid;
    logic                   r_ctrl_append, n_ctrl_append;
    logic                   r_strobe, n_strobe;
    t_result                r_result, n_result;

    logic                   ram_we;
    logic [STORE_W-1:0]     ram_wdata;
    logic [STORE_W-1:0]     ram_rdata;

    logic [7:0]             b;
    logic [ADDR_W-1:0]      comm_addr;
    logic [STORE_W-1:0]     rd_val;
    logic [1:0]             byte_sel;
    logic [31:0]            wr_shift;
    logic [4:0]             ones_next;
    logic [3:0]             ch;
    logic [23:0]            err_next;

    spiadc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (i_item.mosi_byte[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign b         = r_item.mosi_byte;
    assign comm_addr = b[ADDR_W-1:0];
    assign byte_sel  = 2'(r_bytes_left - 3'd1);
    assign wr_shift  = {r_shift[23:0], b};
    assign ones_next = 5'(r_ones) + 5'd1;
    assign err_next  = r_error | r_item.error_bits;

    // read value of the addressed register at the comm byte
    always_comb begin
        case (comm_addr)
            ADDR_STATUS: rd_val = {16'd0, r_status};
            ADDR_DATA:   rd_val = r_data;
            ADDR_ID:     rd_val = {16'd0, i_device_id};
            ADDR_ERROR:  rd_val = r_error;
            ADDR_CLKCNT: rd_val = {16'd0, r_clkcnt};
            default: begin
                if (implemented(comm_addr) && r_valid[comm_addr]) begin
                    rd_val = ram_rdata & size_mask(reg_size(comm_addr));
                end else begin
                    rd_val = '0;
                end
            end
        endcase
    end

    always_comb begin
        if (5'(r_item.sample_channel) >= 5'(NUM_CHANNELS)) begin
            ch = 4'(NUM_CHANNELS - 1);
        end else begin
            ch = r_item.sample_channel;
        end
    end

    always_comb begin
        n_busy        = i_accept;
        n_phase       = r_phase;
        n_addr        = r_addr;
        n_bytes_left  = r_bytes_left;
        n_shift       = r_shift;
        n_ones        = r_ones;
        n_data        = r_data;
        n_status      = r_status;
        n_error       = r_error;
        n_clkcnt      = r_clkcnt;
        n_valid       = r_valid;
        n_ctrl_append = r_ctrl_append;
        n_strobe      = 1'b0;
        n_result      = '0;
        ram_we        = 1'b0;
        ram_wdata     = wr_shift[23:0] & size_mask(reg_size(r_addr));

        if (r_busy) begin
            case (r_item.command)
                CMD_SERIAL: begin
                    n_strobe = 1'b1;
                    if (r_phase == PH_READ && r_bytes_left != 3'd0) begin
                        n_result.miso_byte = 8'(r_shift >> {byte_sel, 3'b000});
                        n_bytes_left = r_bytes_left - 3'd1;
                        if (r_bytes_left == 3'd1) begin
                            n_result.access_done = 1'b1;
                            if (r_addr == ADDR_DATA) begin
                                n_status = r_status | STATUS_NRDY;
                            end
                            n_phase = PH_IDLE;
                        end
                    end else if (r_phase == PH_WRITE && r_bytes_left != 3'd0) begin
                        n_shift      = wr_shift;
                        n_bytes_left = r_bytes_left - 3'd1;
                        if (r_bytes_left == 3'd1) begin
                            n_result.access_done = 1'b1;
                            if (!read_only(r_addr) && implemented(r_addr)) begin
                                ram_we           = 1'b1;
                                n_valid[r_addr]  = 1'b1;
                                if (r_addr == ADDR_CTRL) begin
                                    n_ctrl_append = ram_wdata[CTRL_APPEND_BIT];
                                end
                            end
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                        if (!b[COMM_INVALID_BIT]) begin
                            n_addr       = comm_addr;
                            n_bytes_left = reg_size(comm_addr);
                            if (b[COMM_READ_BIT]) begin
                                n_phase = PH_READ;
                                n_shift = {8'd0, rd_val};
                                if (comm_addr == ADDR_DATA && r_ctrl_append) begin
                                    n_shift      = {rd_val, r_status};
                                    n_bytes_left = 3'd4;
                                end
                            end else begin
                                n_phase = PH_WRITE;
                                n_shift = '0;
                            end
                        end
                    end

                    if (b == ALL_ONES) begin
                        n_ones = ones_next[3:0];
                        if (ones_next >= 5'(RESET_ONES_BYTES)) begin
                            n_phase       = PH_IDLE;
                            n_addr        = '0;
                            n_bytes_left  = '0;
                            n_shift       = '0;
                            n_ones        = '0;
                            n_data        = '0;
                            n_status      = STATUS_NRDY;
                            n_error       = '0;
                            n_clkcnt      = '0;
                            n_valid       = '0;
                            n_ctrl_append = 1'b0;
                        end
                    end else begin
                        n_ones = '0;
                    end
                end
                CMD_SAMPLE: begin
                    n_data   = r_item.sample_value;
                    n_error  = err_next;
                    n_status = ((err_next != 24'd0) ? STATUS_ERR : 8'd0) | {4'd0, ch};
                end
                CMD_TICK: begin
                    n_clkcnt = r_clkcnt + 8'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_phase       <= PH_IDLE;
            r_addr        <= '0;
            r_bytes_left  <= '0;
            r_shift       <= '0;
            r_ones        <= '0;
            r_data        <= '0;
            r_status      <= STATUS_NRDY;
            r_error       <= '0;
            r_clkcnt      <= '0;
            r_valid       <= '0;
            r_ctrl_append <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_busy        <= n_busy;
            r_phase       <= n_phase;
            r_addr        <= n_addr;
            r_bytes_left  <= n_bytes_left;
            r_shift       <= n_shift;
            r_ones        <= n_ones;
            r_data        <= n_data;
            r_status      <= n_status;
            r_error       <= n_error;
            r_clkcnt      <= n_clkcnt;
            r_valid       <= n_valid;
            r_ctrl_append <= n_ctrl_append;
            r_strobe      <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- sv/spi_adc_register_interface_unit.sv -----
// top level of the spi adc register interface: apb id register, sequencer, checks
// depends on spiadc_pkg, spiadc_ctrl and spi_adc_register_interface_unit_defines.svh
//
// usage
// - an item (serial byte, conversion result or clock tick) is taken at a clock
//   edge with start high and busy low
// - busy is high for one cycle after each accepted item; no new item is taken
//   while busy is high, covering the registered read of the register store ram
// - a serial byte gives one result beat on o_result with o_strobe high for one
//   cycle, registered from the busy cycle; other commands give no beat
// - the receiver cannot stall, so every beat must be taken when shown
// - device_id is written over apb at byte address 0 while the block is idle;
//   pready is always high and reads with paddr[2] low return the id, others zero
// - synchronous reset clears the state registers, store valid bits and device_id;
//   no clearing pass is needed and the block takes items right after reset
// - eight consecutive 0xff serial bytes reset everything but device_id
module spi_adc_register_interface_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  spiadc_pkg::t_item    i_item,
    output logic                 o_strobe,
    output spiadc_pkg::t_result  o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import spiadc_pkg::*;

    logic       r_device_id_valid;
    logic [7:0] r_device_id, n_device_id;
    logic       accept;
    logic       cfg_write;

    assign accept    = start && !busy;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_device_id = r_device_id;
        if (cfg_write && !paddr[2]) begin
            n_device_id = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id       <= '0;
            r_device_id_valid <= 1'b0;
        end else begin
            r_device_id       <= n_device_id;
            r_device_id_valid <= 1'b1;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_device_id};

    spiadc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_device_id (r_device_id),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

`include "spi_adc_register_interface_unit_defines.svh"

    `SPIADC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "accepted item did not raise busy")
    `SPIADC_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy) && r_device_id_valid, "result beat without a processed item")
    `SPIADC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "result beats back to back")
    `SPIADC_ASSERT_NOW(a_busy_single, i_clk, i_rst_n, busy, !$past(busy), "busy held longer than one cycle")

endmodule

// ----- verif/spi_adc_register_interface_unit_checker.sv -----
// register map helpers and the result checker for the spi adc register interface
// depends on spiadc_pkg; the checker is instantiated by spi_adc_register_interface_unit_tb
package spiadc_regmap_pkg;

    import spiadc_pkg::*;

    localparam logic [2:0] CFG_ADDR_ID  = 3'd0;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    function automatic int unsigned access_bytes(input logic [5:0] a);
        if (a >= ADDR_WIDE_BASE || a == ADDR_DATA || a == ADDR_IO1 || a == ADDR_ERROR ||
            a == ADDR_ERROR_EN) begin
            return 3;
        end
        if (a >= ADDR_CH_BASE || a == ADDR_CTRL || a == ADDR_IO2) begin
            return 2;
        end
        return 1;
    endfunction

    function automatic logic [23:0] width_mask(input int unsigned n);
        if (n == 3) begin
            return 24'hffffff;
        end
        return (n == 2) ? 24'h00ffff : 24'h0000ff;
    endfunction

    function automatic bit is_backed(input logic [5:0] a);
        if (a >= ADDR_CH_BASE && a < ADDR_SETUP_BASE) begin
            return int'(a - ADDR_CH_BASE) < NUM_CHANNELS;
        end
        if (a >= ADDR_SETUP_BASE && a < ADDR_UNIMPL) begin
            return int'(3'(a - ADDR_SETUP_BASE)) < NUM_SETUPS;
        end
        return a < ADDR_UNIMPL;
    endfunction

    function automatic bit is_locked(input logic [5:0] a);
        return a == ADDR_STATUS || a == ADDR_DATA || a == ADDR_ID || a == ADDR_ERROR ||
               a == ADDR_CLKCNT;
    endfunction

endpackage

module spi_adc_register_interface_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  spiadc_pkg::t_item   i_item,
    input  logic                i_strobe,
    input  spiadc_pkg::t_result i_result,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    input  logic                i_pready,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spiadc_pkg::*;
    import spiadc_regmap_pkg::*;

    logic [23:0] reg_file [64];
    t_phase      phase_q;
    logic [5:0]  addr_q;
    logic [2:0]  left_q;
    logic [31:0] shift_q;
    logic [3:0]  ones_run;
    logic [23:0] sample_q;
    logic [7:0]  status_q;
    logic [23:0] err_q;
    logic [7:0]  tick_q;
    logic [7:0]  id_q;
    t_result     miso_due [$];
    int          fails = 0;

    function automatic void clear_device();
        foreach (reg_file[i]) begin
            reg_file[i] = '0;
        end
        phase_q  = PH_IDLE;
        addr_q   = '0;
        left_q   = '0;
        shift_q  = '0;
        ones_run = '0;
        sample_q = '0;
        status_q = STATUS_NRDY;
        err_q    = '0;
        tick_q   = '0;
    endfunction

    function automatic logic [23:0] register_value(input logic [5:0] a);
        case (a)
            ADDR_STATUS: return {16'h0, status_q};
            ADDR_DATA:   return sample_q;
            ADDR_ID:     return {16'h0, id_q};
            ADDR_ERROR:  return err_q;
            ADDR_CLKCNT: return {16'h0, tick_q};
            default:     return is_backed(a) ? (reg_file[a] & width_mask(access_bytes(a))) : '0;
        endcase
    endfunction

    function automatic void clock_in_mosi(input logic [7:0] b);
        t_result r;
        r = '0;
        if (phase_q == PH_READ && left_q != 0) begin
            r.miso_byte = 8'(shift_q >> (8 * ((int'(left_q) - 1) & 3)));
            left_q = left_q - 3'd1;
            if (left_q == 0) begin
                r.access_done = 1'b1;
                if (addr_q == ADDR_DATA) begin
                    status_q = status_q | STATUS_NRDY;
                end
                phase_q = PH_IDLE;
            end
        end else if (phase_q == PH_WRITE && left_q != 0) begin
            shift_q = {shift_q[23:0], b};
            left_q = left_q - 3'd1;
            if (left_q == 0) begin
                r.access_done = 1'b1;
                if (!is_locked(addr_q) && is_backed(addr_q)) begin
                    reg_file[addr_q] = shift_q[23:0] & width_mask(access_bytes(addr_q));
                end
                phase_q = PH_IDLE;
            end
        end else begin
            phase_q = PH_IDLE;
            if (!b[COMM_INVALID_BIT]) begin
                addr_q = b[5:0];
                left_q = 3'(access_bytes(addr_q));
                if (b[COMM_READ_BIT]) begin
                    phase_q = PH_READ;
                    shift_q = {8'h0, register_value(addr_q)};
                    // status byte appended to a data read
                    if (addr_q == ADDR_DATA && reg_file[ADDR_CTRL][CTRL_APPEND_BIT]) begin
                        shift_q = {shift_q[23:0], status_q};
                        left_q  = 3'd4;
                    end
                end else begin
                    phase_q = PH_WRITE;
                    shift_q = '0;
                end
            end
        end
        miso_due.push_back(r);
        if (b == ALL_ONES) begin
            ones_run = ones_run + 4'd1;
            if (int'(ones_run) >= RESET_ONES_BYTES) begin
                clear_device();
            end
        end else begin
            ones_run = '0;
        end
    endfunction

    function automatic void take_sample(input t_item it);
        int ch;
        ch = int'(it.sample_channel);
        if (ch >= NUM_CHANNELS) begin
            ch = NUM_CHANNELS - 1;
        end
        sample_q = it.sample_value;
        err_q    = err_q | it.error_bits;
        status_q = ((err_q != 0) ? STATUS_ERR : 8'h00) | 8'(ch);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_device();
            id_q = '0;
            miso_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == CFG_ADDR_ID[2]) begin
                id_q = i_pwdata[7:0];
            end
            if (i_start && !i_busy) begin
                case (i_item.command)
                    CMD_SERIAL:   clock_in_mosi(i_item.mosi_byte);
                    CMD_SAMPLE:   take_sample(i_item);
                    CMD_TICK:     tick_q = tick_q + 8'd1;
                    CMD_RESERVED: ;
                    default:      ;
                endcase
            end
            if (i_strobe) begin
                if (miso_due.size() == 0) begin
                    fails++;
                    $display("%0t: beat expected none, got miso %02h done %0b",
                             $time, i_result.miso_byte, i_result.access_done);
                end else begin
                    want = miso_due.pop_front();
                    if (i_result.miso_byte !== want.miso_byte) begin
                        fails++;
                        $display("%0t: miso_byte expected %02h got %02h",
                                 $time, want.miso_byte, i_result.miso_byte);
                    end
                    if (i_result.access_done !== want.access_done) begin
                        fails++;
                        $display("%0t: access_done expected %0b got %0b",
                                 $time, want.access_done, i_result.access_done);
                    end
                end
            end
        end
        o_pending    = miso_due.size();
        o_fail_count = fails;
    end

endmodule

// ----- verif/spi_adc_register_interface_unit_tb.sv -----
// stimulus and verdict for the spi adc register interface unit
// depends on spiadc_pkg, spiadc_regmap_pkg, the checker and the block itself
module spi_adc_register_interface_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spiadc_pkg::*;
    import spiadc_regmap_pkg::*;

    localparam int ITEMS        = 1500;
    localparam int SETTLE_WAIT  = 8;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    t_item       item_drv = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          append_on  = 1'b0;

    spi_adc_register_interface_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_drv),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    spi_adc_register_interface_unit_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item_drv),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_item noise_item();
        t_item it;
        it.command        = 2'($urandom_range(0, 3));
        it.mosi_byte      = 8'($urandom);
        it.sample_value   = 24'($urandom);
        it.sample_channel = 4'($urandom);
        it.error_bits     = 24'($urandom);
        return it;
    endfunction

    task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_item(input t_item it);
        int pause;
        item_drv <= it;
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.command != CMD_RESERVED) begin
            items_sent++;
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (pause != 0) begin
                start    <= 1'b0;
                item_drv <= noise_item();
                repeat (pause) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_item it;
        it = noise_item();
        it.command   = CMD_SERIAL;
        it.mosi_byte = b;
        push_item(it);
    endtask

    task automatic send_sample(input logic [23:0] v, input logic [3:0] ch,
                               input logic [23:0] err);
        t_item it;
        it = noise_item();
        it.command        = CMD_SAMPLE;
        it.sample_value   = v;
        it.sample_channel = ch;
        it.error_bits     = err;
        push_item(it);
    endtask

    task automatic send_cmd(input logic [1:0] c);
        t_item it;
        it = noise_item();
        it.command = c;
        push_item(it);
    endtask

    task automatic reg_access(input bit rd, input logic [5:0] a, input logic [31:0] d);
        int n;
        n = access_bytes(a);
        if (rd && a == ADDR_DATA && append_on) begin
            n = 4;
        end
        send_byte({1'b0, rd, a});
        for (int i = 0; i < n; i++) begin
            send_byte(rd ? 8'($urandom) : d[8 * (n - 1 - i) +: 8]);
        end
        if (!rd && a == ADDR_CTRL) begin
            append_on = d[CTRL_APPEND_BIT];
        end
    endtask

    task automatic serial_reset();
        repeat (RESET_ONES_BYTES) send_byte(ALL_ONES);
        append_on = 1'b0;
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        start <= 1'b0;
        do begin
            @(negedge i_clk);
            guard++;
        end while (pending != 0 && guard < 1000);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic run_directed();
        reg_access(1'b1, ADDR_ID, '0);
        send_sample(24'hffffff, 4'hf, 24'h800001);
        reg_access(1'b0, ADDR_CTRL, 32'h0000_0400);
        // sample arriving in the middle of a data read
        send_byte({2'b01, ADDR_DATA});
        send_byte(8'h00);
        send_sample(24'h000000, 4'h0, 24'h000000);
        repeat (3) send_byte(8'h5a);
        append_on = 1'b1;
        send_byte(8'h80);
        reg_access(1'b0, ADDR_UNIMPL, 32'h00a5_a5a5);
        send_cmd(CMD_TICK);
        send_cmd(CMD_RESERVED);
        reg_access(1'b1, ADDR_CLKCNT, '0);
        serial_reset();
    endtask

    task automatic random_transaction();
        int          pick;
        int          n;
        logic [5:0]  a;
        logic [23:0] err;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            case ($urandom_range(0, 5))
                0: a = ADDR_CTRL;
                1: begin
                    case ($urandom_range(0, 4))
                        0:       a = ADDR_STATUS;
                        1:       a = ADDR_ID;
                        2:       a = ADDR_ERROR;
                        3:       a = ADDR_CLKCNT;
                        default: a = ADDR_DATA;
                    endcase
                end
                2: a = 6'($urandom_range(ADDR_CH_BASE, ADDR_UNIMPL - 1));
                3: a = 6'($urandom_range(ADDR_UNIMPL, 63));
                4: a = ADDR_DATA;
                default: a = 6'($urandom);
            endcase
            reg_access(1'($urandom), a, $urandom);
        end else if (pick < 70) begin
            err = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'h0;
            send_sample(24'($urandom), 4'($urandom), err);
        end else if (pick < 78) begin
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 8);
            repeat (n) send_cmd(CMD_TICK);
        end else if (pick < 82) begin
            send_cmd(CMD_RESERVED);
        end else if (pick < 88) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, RESET_ONES_BYTES - 1)) send_byte(ALL_ONES);
            end else begin
                serial_reset();
            end
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            // bytes with the top bit set bring the framing back to idle
            repeat (4) send_byte(8'($urandom_range(8'h80, 8'hfe)));
        end
    endtask

    initial begin
        logic [7:0] id_plan [4];
        id_plan = '{8'hff, 8'h00, 8'($urandom), 8'($urandom)};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 4; p++) begin
            cfg_write(CFG_ADDR_ID, {24'($urandom), id_plan[p]});
            if (p == 0) begin
                run_directed();
            end
            while (items_sent < (p + 1) * ITEMS / 4) begin
                random_transaction();
            end
            settle();
        end
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/spiadc_pkg.sv
sv/spiadc_ram.sv
sv/spiadc_ctrl.sv
sv/spi_adc_register_interface_unit.sv
verif/spi_adc_register_interface_unit_checker.sv
verif/spi_adc_register_interface_unit_tb.sv
